>>> sv/ir_pkg.sv
// Package for the integer radical block.
// Holds the command and status bundles passed between controller and datapath.
// No dependencies.
package ir_pkg;

  typedef struct packed {
    logic load;
    logic div_start;
    logic mul_start;
    logic mul_sel_n;
    logic n_take_q;
    logic d_inc;
    logic out_load;
  } ir_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_gt1;
    logic div_busy;
    logic mul_busy;
    logic q_lt_d;
    logic r_zero;
  } ir_stat_t;

endpackage

>>> sv/ir_dpath.sv
// Datapath of the integer radical block: value, divisor and product registers,
// a shift-subtract divider and a shift-add multiplier.
// Depends on ir_pkg.
module ir_dpath
  import ir_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ir_cmd_t              cmd,
  input  logic [WORD_BITS-1:0] in_number,
  output ir_stat_t             stat,
  output logic [WORD_BITS-1:0] out_radical
);

  localparam int CW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] n_r, n_nxt;
  logic [WORD_BITS-1:0] d_r, d_nxt;
  logic [WORD_BITS-1:0] prod_r, prod_nxt;
  logic [WORD_BITS-1:0] quo_r, quo_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] ma_r, ma_nxt;
  logic [WORD_BITS-1:0] mb_r, mb_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] radical_r, radical_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 div_busy_r, div_busy_nxt;
  logic                 mul_busy_r, mul_busy_nxt;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic                 qbit;

  always_comb begin
    trial        = {rem_r, quo_r[WORD_BITS-1]};
    diff         = trial - {1'b0, d_r};
    qbit         = ~diff[WORD_BITS];
    n_nxt        = n_r;
    d_nxt        = d_r;
    prod_nxt     = prod_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    ma_nxt       = ma_r;
    mb_nxt       = mb_r;
    acc_nxt      = acc_r;
    radical_nxt  = radical_r;
    cnt_nxt      = cnt_r;
    div_busy_nxt = div_busy_r;
    mul_busy_nxt = mul_busy_r;

    if (cmd.load) begin
      n_nxt    = in_number;
      d_nxt    = WORD_BITS'(2);
      prod_nxt = WORD_BITS'(1);
    end
    if (cmd.n_take_q) begin
      n_nxt = quo_r;
    end
    if (cmd.d_inc) begin
      d_nxt = d_r + WORD_BITS'(1);
    end

    if (cmd.div_start) begin
      quo_nxt      = n_r;
      rem_nxt      = '0;
      cnt_nxt      = CW'(WORD_BITS - 1);
      div_busy_nxt = 1'b1;
    end else if (div_busy_r) begin
      rem_nxt = qbit ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      quo_nxt = {quo_r[WORD_BITS-2:0], qbit};
      if (cnt_r == '0) begin
        div_busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end

    if (cmd.mul_start) begin
      ma_nxt       = prod_r;
      mb_nxt       = cmd.mul_sel_n ? n_r : d_r;
      acc_nxt      = '0;
      mul_busy_nxt = 1'b1;
    end else if (mul_busy_r) begin
      if (mb_r == '0) begin
        prod_nxt     = acc_r;
        mul_busy_nxt = 1'b0;
      end else begin
        if (mb_r[0]) begin
          acc_nxt = acc_r + ma_r;
        end
        ma_nxt = {ma_r[WORD_BITS-2:0], 1'b0};
        mb_nxt = {1'b0, mb_r[WORD_BITS-1:1]};
      end
    end

    if (cmd.out_load) begin
      radical_nxt = prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      mul_busy_r <= 1'b0;
    end else begin
      div_busy_r <= div_busy_nxt;
      mul_busy_r <= mul_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    prod_r    <= prod_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    acc_r     <= acc_nxt;
    radical_r <= radical_nxt;
    cnt_r     <= cnt_nxt;
  end

  assign stat.n_lt2    = (n_r < WORD_BITS'(2));
  assign stat.n_gt1    = (n_r > WORD_BITS'(1));
  assign stat.div_busy = div_busy_r;
  assign stat.mul_busy = mul_busy_r;
  assign stat.q_lt_d   = (quo_r < d_r);
  assign stat.r_zero   = (rem_r == '0);
  assign out_radical   = radical_r;

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_busy_r && mul_busy_r))
    else $error("divider and multiplier busy together");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy_r)
    else $error("division started while busy");

  a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy_r |-> (d_r >= WORD_BITS'(2)))
    else $error("trial divisor below two");

  a_mul_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !mul_busy_r && !div_busy_r)
    else $error("multiplication started while a unit is busy");

endmodule

>>> sv/ir_ctrl.sv
// Controller of the integer radical block: sequences trial division,
// factor stripping and product updates, and owns the handshakes.
// Depends on ir_pkg.
module ir_ctrl
  import ir_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ir_stat_t stat,
  output ir_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_CHECK     = 11'b000_0000_0010,
    S_DIV       = 11'b000_0000_0100,
    S_DIV_WAIT  = 11'b000_0000_1000,
    S_MUL_D     = 11'b000_0001_0000,
    S_STRIP     = 11'b000_0010_0000,
    S_STRIP_W   = 11'b000_0100_0000,
    S_FIN       = 11'b000_1000_0000,
    S_MUL_N     = 11'b001_0000_0000,
    S_DONE      = 11'b010_0000_0000,
    S_SPARE     = 11'b100_0000_0000
  } ir_state_t;

  ir_state_t state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = stat.n_lt2 ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!stat.div_busy) begin
          if (stat.q_lt_d) begin
            state_nxt = S_FIN;
          end else if (stat.r_zero) begin
            cmd.mul_start = 1'b1;
            cmd.n_take_q  = 1'b1;
            state_nxt     = S_MUL_D;
          end else begin
            cmd.d_inc = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_MUL_D: begin
        if (!stat.mul_busy) begin
          state_nxt = S_STRIP;
        end
      end
      S_STRIP: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_STRIP_W;
      end
      S_STRIP_W: begin
        if (!stat.div_busy) begin
          if (stat.r_zero) begin
            cmd.n_take_q = 1'b1;
            state_nxt    = S_STRIP;
          end else begin
            cmd.d_inc = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_FIN: begin
        if (stat.n_gt1) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel_n = 1'b1;
          state_nxt     = S_MUL_N;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL_N: begin
        if (!stat.mul_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded but not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.out_load)
    else $error("pending transaction overwritten");

endmodule

>>> sv/integer_radical.sv
// Integer radical: returns the product of the distinct prime factors of an
// unsigned WORD_BITS-bit number (0 and 1 give 1). Trial divisors run from 2
// up to the square root of the remaining value through one shift-subtract
// divider. Each distinct factor adds a product update on the shift-add
// multiplier, and each repeated factor is stripped by a further division.
// One number is worked at a time; a finished result waits in the output
// register while the next number is accepted.
// Depends on ir_pkg, ir_ctrl and ir_dpath.
module integer_radical
  import ir_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] in_number,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_radical
);

  ir_cmd_t  cmd;
  ir_stat_t stat;

  ir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ir_dpath #(
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_number   (in_number),
    .stat        (stat),
    .out_radical (out_radical)
  );

endmodule

>>> bench/tb_top.sv
// Testbench for integer_radical: directed and random numbers with a local radical predictor.
// Each result is checked in order, under random idle cycles, stalls and a long output hold-off.
// Depends on the integer_radical RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int WORD_BITS    = 32;
  localparam int CYCLE_LIMIT  = 15_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 2000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic [WORD_BITS-1:0] in_number = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  logic [WORD_BITS-1:0] out_radical;

  logic [WORD_BITS-1:0] radical_q[$];
  logic [WORD_BITS-1:0] expected_radical;
  int                   mismatches  = 0;
  bit                   send_gaps   = 1'b1;
  bit                   recv_gaps   = 1'b1;
  int                   hold_cycles = 0;

  always #1 clk = ~clk;

  integer_radical #(
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_number  (in_number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_radical(out_radical)
  );

  function automatic logic [WORD_BITS-1:0] radical_of_number(logic [WORD_BITS-1:0] value);
    longint unsigned rest;
    longint unsigned divisor;
    longint unsigned product;
    rest    = 64'(value);
    divisor = 2;
    product = 1;
    if (rest < 2) return WORD_BITS'(1);
    while (divisor <= rest / divisor) begin
      if (rest % divisor == 0) begin
        product = product * divisor;
        do rest = rest / divisor; while (rest % divisor == 0);
      end
      divisor++;
    end
    if (rest > 1) product = product * rest;
    return WORD_BITS'(product);
  endfunction

  function automatic logic [WORD_BITS-1:0] shifted_number();
    logic [WORD_BITS-1:0] value;
    value = $urandom_range(0, 65535);
    value = value << $urandom_range(0, 16);
    return value;
  endfunction

  function automatic logic [WORD_BITS-1:0] smooth_number();
    longint unsigned acc;
    longint unsigned factor;
    acc = 1;
    repeat (12) begin
      factor = 64'($urandom_range(2, 255));
      if (acc * factor <= 64'hFFFF_FFFF) acc = acc * factor;
    end
    return WORD_BITS'(acc);
  endfunction

  task automatic send_number(input logic [WORD_BITS-1:0] value);
    int gap;
    gap = send_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    radical_q.push_back(radical_of_number(value));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (radical_q.size() != 0) @(posedge clk);
  endtask

  task automatic pick_idling();
    send_gaps = $urandom_range(0, 3) != 0;
    recv_gaps = $urandom_range(0, 3) != 0;
  endtask

  task automatic test_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_directed();
    logic [WORD_BITS-1:0] values[] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd7, 32'd8, 32'd9, 32'd30, 32'd36,
      32'd63001, 32'd65536, 32'd65537, 32'd223092870, 32'd3486784401,
      32'h8000_0000, 32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
      32'hFFFF_FFFF, 32'hFFFF_FFFB
    };
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    foreach (values[i]) send_number(values[i]);
  endtask

  task automatic test_random_shifted();
    for (int i = 0; i < 40; i++) begin
      if (i % 10 == 0) pick_idling();
      send_number(shifted_number());
    end
  endtask

  task automatic test_random_smooth();
    for (int i = 0; i < 30; i++) begin
      if (i % 10 == 0) pick_idling();
      send_number(smooth_number());
    end
  endtask

  task automatic test_back_to_back();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) send_number($urandom_range(0, 255));
      else send_number(shifted_number());
    end
  endtask

  task automatic test_output_hold();
    stop_sending();
    wait_for_results();
    send_gaps   = 1'b0;
    recv_gaps   = 1'b1;
    hold_cycles = LONG_HOLD;
    repeat (8) send_number($urandom_range(0, 255));
  endtask

  task automatic test_drain_pause();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    repeat (4) send_number(smooth_number());
    stop_sending();
    wait_for_results();
    repeat (4) send_number(shifted_number());
  endtask

  // receiver: hold off a drawn number of cycles, then take one transaction
  initial begin
    int wait_cycles;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_cycles = recv_gaps ? $urandom_range(0, 15) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (radical_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: radical %h", out_radical);
        mismatches++;
      end else begin
        expected_radical = radical_q.pop_front();
        if (out_radical !== expected_radical) begin
          if (mismatches < 10) begin
            $display("radical mismatch: expected %h actual %h", expected_radical, out_radical);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    test_reset();
    test_directed();
    test_random_shifted();
    test_random_smooth();
    test_back_to_back();
    test_output_hold();
    test_drain_pause();
    stop_sending();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ir_pkg.sv
sv/ir_dpath.sv
sv/ir_ctrl.sv
sv/integer_radical.sv
bench/tb_top.sv
